// ===== rtl/core/mdhc_pkg.sv =====
package mdhc_pkg;

	localparam int HEADER_BYTES = 36;
	localparam int POS_W = $clog2(HEADER_BYTES + 1);
	localparam logic [31:0] MAGIC_VALUE = 32'h3153_4250;

	// Header byte offsets
	localparam int OFS_MAGIC = 0;
	localparam int OFS_VERSION = 4;
	localparam int OFS_KIND = 5;
	localparam int OFS_CODEC = 6;
	localparam int OFS_FLAGS = 7;
	localparam int OFS_SEQ = 8;
	localparam int OFS_FRAME = 12;
	localparam int OFS_TIME = 20;
	localparam int OFS_IDX = 28;
	localparam int OFS_CNT = 30;
	localparam int OFS_LEN = 32;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_SHORT = 3'd1;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
	localparam logic [2:0] ST_BAD_VERSION = 3'd3;
	localparam logic [2:0] ST_LEN_MISMATCH = 3'd4;
	localparam logic [2:0] ST_BAD_CHUNKS = 3'd5;

	// Result queue
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic        is_summary;
		logic [7:0]  payload_byte;
		logic [2:0]  status;
		logic [7:0]  stream_kind;
		logic [7:0]  codec;
		logic [7:0]  frame_flags;
		logic [31:0] sequence_number;
		logic [63:0] frame_number;
		logic [63:0] timestamp;
		logic [15:0] piece_index;
		logic [15:0] piece_count;
		logic        last_of_run;
	} res_t;

	// Results produced by one input byte: count (0..2) and the two slots.
	typedef struct packed {
		logic [1:0] n;
		res_t       first;
		res_t       second;
	} push_t;

endpackage

// ===== rtl/core/mdhc_parse.sv =====
module mdhc_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data,
	input  logic                room,
	output mdhc_pkg::push_t     push
);
	import mdhc_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic [7:0]       exp_version_q;
	logic [POS_W-1:0] pos_q;
	logic [31:0]      seen_q;
	logic [7:0]       hdr_q [HEADER_BYTES];
	logic [7:0]       hdr_eff [HEADER_BYTES];
	logic             adv;
	logic             in_hdr;
	logic [POS_W-1:0] pos_next;
	logic [31:0]      seen_next;
	logic [31:0]      magic;
	logic [31:0]      decl_len;
	logic [15:0]      idx;
	logic [15:0]      cnt;
	logic [2:0]       st;
	res_t             pay_res;
	res_t             sum_res;

	assign in_stall = valid_s1 && !room;
	assign adv = valid_s1 && room;
	assign in_hdr = pos_q < POS_W'(HEADER_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_version_q <= 8'd1;
		end else if (cfg_wr_en) begin
			exp_version_q <= cfg_wr_data;
		end
	end

	// The current byte is merged in so that a datagram ending on the last
	// header byte is checked against the complete header.
	always_comb begin
		for (int i = 0; i < HEADER_BYTES; i++) begin
			hdr_eff[i] = (in_hdr && pos_q == POS_W'(i)) ? byte_s1 : hdr_q[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < HEADER_BYTES; i++) begin
			if (adv && in_hdr && pos_q == POS_W'(i)) begin
				hdr_q[i] <= byte_s1;
			end
		end
	end

	assign pos_next = in_hdr ? pos_q + POS_W'(1) : pos_q;
	assign seen_next = (in_hdr || seen_q == '1) ? seen_q : seen_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			seen_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				pos_q <= '0;
				seen_q <= '0;
			end else begin
				pos_q <= pos_next;
				seen_q <= seen_next;
			end
		end
	end

	assign magic = {hdr_eff[OFS_MAGIC+3], hdr_eff[OFS_MAGIC+2],
		hdr_eff[OFS_MAGIC+1], hdr_eff[OFS_MAGIC]};
	assign decl_len = {hdr_eff[OFS_LEN+3], hdr_eff[OFS_LEN+2],
		hdr_eff[OFS_LEN+1], hdr_eff[OFS_LEN]};
	assign idx = {hdr_eff[OFS_IDX+1], hdr_eff[OFS_IDX]};
	assign cnt = {hdr_eff[OFS_CNT+1], hdr_eff[OFS_CNT]};

	always_comb begin
		if (pos_next < POS_W'(HEADER_BYTES)) begin
			st = ST_SHORT;
		end else if (magic != MAGIC_VALUE) begin
			st = ST_BAD_MAGIC;
		end else if (hdr_eff[OFS_VERSION] != exp_version_q) begin
			st = ST_BAD_VERSION;
		end else if (decl_len != seen_next) begin
			st = ST_LEN_MISMATCH;
		end else if (cnt == 16'd0 || idx >= cnt) begin
			st = ST_BAD_CHUNKS;
		end else begin
			st = ST_OK;
		end
	end

	always_comb begin
		pay_res = '0;
		pay_res.payload_byte = byte_s1;
		pay_res.last_of_run = !last_s1;

		sum_res = '0;
		sum_res.is_summary = 1'b1;
		sum_res.status = st;
		sum_res.last_of_run = 1'b1;
		if (st == ST_OK) begin
			sum_res.stream_kind = hdr_eff[OFS_KIND];
			sum_res.codec = hdr_eff[OFS_CODEC];
			sum_res.frame_flags = hdr_eff[OFS_FLAGS];
			sum_res.sequence_number = {hdr_eff[OFS_SEQ+3], hdr_eff[OFS_SEQ+2],
				hdr_eff[OFS_SEQ+1], hdr_eff[OFS_SEQ]};
			sum_res.frame_number = {hdr_eff[OFS_FRAME+7], hdr_eff[OFS_FRAME+6],
				hdr_eff[OFS_FRAME+5], hdr_eff[OFS_FRAME+4], hdr_eff[OFS_FRAME+3],
				hdr_eff[OFS_FRAME+2], hdr_eff[OFS_FRAME+1], hdr_eff[OFS_FRAME]};
			sum_res.timestamp = {hdr_eff[OFS_TIME+7], hdr_eff[OFS_TIME+6],
				hdr_eff[OFS_TIME+5], hdr_eff[OFS_TIME+4], hdr_eff[OFS_TIME+3],
				hdr_eff[OFS_TIME+2], hdr_eff[OFS_TIME+1], hdr_eff[OFS_TIME]};
			sum_res.piece_index = idx;
			sum_res.piece_count = cnt;
		end
	end

	always_comb begin
		push.first = in_hdr ? sum_res : pay_res;
		push.second = sum_res;
		if (!adv) begin
			push.n = 2'd0;
		end else begin
			push.n = {1'b0, !in_hdr} + {1'b0, last_s1};
		end
	end

endmodule

// ===== rtl/core/mdhc_outq.sv =====
module mdhc_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  mdhc_pkg::push_t     push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_stall,
	output mdhc_pkg::res_t      head
);
	import mdhc_pkg::*;

	res_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               pop;

	// Room for the two results that one byte can produce.
	assign room = cnt_q <= Q_CNT_W'(Q_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign pop = out_valid && !out_stall;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + Q_PTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			cnt_q <= cnt_q + Q_CNT_W'(push.n) - Q_CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/core/media_datagram_header_checker_top.sv =====
// Each byte is registered in the input stage; its results are then written
// into a four-entry result queue, whose head is offered on the outputs.
// Throughput: one byte per cycle while in_stall is low; a datagram's final
// payload byte yields two results, drained one per cycle while out_stall is low.
// Reset (arst_n low, asynchronous) clears the header position, payload count
// and the queue, and sets expected_version to 1.
module media_datagram_header_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_summary,
	output logic [7:0]  payload_byte,
	output logic [2:0]  status,
	output logic [7:0]  stream_kind,
	output logic [7:0]  codec,
	output logic [7:0]  frame_flags,
	output logic [31:0] sequence_number,
	output logic [63:0] frame_number,
	output logic [63:0] timestamp,
	output logic [15:0] piece_index,
	output logic [15:0] piece_count,
	output logic        last_of_run
);
	import mdhc_pkg::*;

	push_t push;
	res_t  head;
	logic  room;

	mdhc_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.room        (room),
		.push        (push)
	);

	mdhc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign is_summary = head.is_summary;
	assign payload_byte = head.payload_byte;
	assign status = head.status;
	assign stream_kind = head.stream_kind;
	assign codec = head.codec;
	assign frame_flags = head.frame_flags;
	assign sequence_number = head.sequence_number;
	assign frame_number = head.frame_number;
	assign timestamp = head.timestamp;
	assign piece_index = head.piece_index;
	assign piece_count = head.piece_count;
	assign last_of_run = head.last_of_run;

endmodule
